/* rtl/core/qpskcd_pkg.sv */
// Shared types and constants for the QPSK correlation demodulator.
// No dependencies.
`default_nettype none

package qpskcd_pkg;

  // Defaults for the top level parameters
  localparam int SampleWidthDef   = 16;
  localparam int MaxSamplesDef    = 64;
  localparam int CarrierPeriodDef = 10;

  // Configuration registers
  localparam int SpsW     = 7;
  localparam int PhaseW   = 3;
  localparam int CfgDataW = 7;
  localparam int CfgIdxW  = 1;

  localparam logic [SpsW-1:0]   SpsResetVal   = 7'd40;
  localparam logic [PhaseW-1:0] PhaseResetVal = 3'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSps   = 1'b0,
    CfgPhase = 1'b1
  } cfg_reg_e;

  // Result beat layout
  localparam int ErrTotalW   = 16;
  localparam int OutDataW    = 24;
  localparam int OutBitMsb   = 0;
  localparam int OutBitLsb   = 1;
  localparam int OutErrMsb   = 2;
  localparam int OutErrLsb   = 3;
  localparam int OutTotalLsb = 4;

  // Reference coefficients, Q14
  localparam int CoefW = 16;

  typedef struct packed {
    logic signed [CoefW-1:0] cos_v;
    logic signed [CoefW-1:0] sin_v;
  } coef_t;

  localparam longint PiQ30  = 64'sd3373259426;
  localparam longint OneQ30 = 64'sd1073741824;

endpackage

`default_nettype wire

/* rtl/core/qpsk_correlation_demodulator_top.sv */
// Top level of the QPSK correlation demodulator: sample stream in, one
// decision beat per symbol out. Uses qpskcd_pkg and qpskcd_carrier_rom.
`default_nettype none

// Takes one sample beat per clock and returns one result beat at the end of
// each symbol (after samples_per_symbol input beats). A sample passes three
// register stages: coefficient lookup, multiply, accumulate/decide, so a
// result beat is registered in the decision stage once the symbol's last
// input beat has passed the lookup and multiply registers. The accumulate
// loop is a single feedback register, which sets the sustained rate of one
// sample per cycle when no stall holds input. A held result beat stalls
// input only once a later symbol's last sample reaches the decision stage.
// Config writes must be issued while no samples are in flight.
module qpsk_correlation_demodulator_top import qpskcd_pkg::*; #(
  parameter int SampleWidth   = SampleWidthDef,
  parameter int MaxSamples    = MaxSamplesDef,
  parameter int CarrierPeriod = CarrierPeriodDef
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // sample beats
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // sample, ref_msb, ref_lsb (zero padded to bytes)
  input  wire logic [((SampleWidth+2+7)/8)*8-1:0]       s_axis_tdata,
  // result beats
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // bit_msb, bit_lsb, err_msb, err_lsb, error_total[15:0], zero pad
  output logic [OutDataW-1:0]                           m_axis_tdata,
  // register writes
  input  wire logic                                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]                       cfg_idx_i,
  input  wire logic [CfgDataW-1:0]                      cfg_data_i
);

  localparam int IdxW     = $clog2(MaxSamples);
  localparam int LenW     = $clog2(MaxSamples + 1);
  localparam int CmpW     = (LenW > SpsW) ? LenW : SpsW;
  localparam int CarW     = $clog2(CarrierPeriod);
  localparam int TabDepth = 8 * CarrierPeriod;
  localparam int AngW     = $clog2(TabDepth);
  localparam int SumW     = $clog2(15 * CarrierPeriod);
  localparam int ProdW    = SampleWidth + CoefW;
  localparam int AccW     = ProdW + $clog2(MaxSamples);
  localparam int ErrSumW  = ErrTotalW + 1;

  // Configuration
  logic [SpsW-1:0]   sps_q;
  logic [PhaseW-1:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q   <= SpsResetVal;
      phase_q <= PhaseResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgSps:   sps_q   <= cfg_data_i[SpsW-1:0];
        CfgPhase: phase_q <= cfg_data_i[PhaseW-1:0];
        default:  ;
      endcase
    end
  end

  // Effective symbol length: zero acts as one, clamp to MaxSamples
  logic [CmpW-1:0] len_eff;
  always_comb begin
    if (sps_q == '0) begin
      len_eff = CmpW'(1);
    end else if (CmpW'(sps_q) > CmpW'(MaxSamples)) begin
      len_eff = CmpW'(MaxSamples);
    end else begin
      len_eff = CmpW'(sps_q);
    end
  end

  // Handshake chain
  logic v1_q, v2_q, out_valid_q;
  logic last1_q, last2_q;
  logic in_fire, fire1, fire2, out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire2         = v2_q && (!last2_q || out_free);
  assign fire1         = v1_q && (!v2_q || fire2);
  assign s_axis_tready = !v1_q || fire1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Symbol position counters
  logic [IdxW-1:0] sample_idx_q;
  logic [CarW-1:0] car_idx_q;
  logic [CmpW-1:0] idx_next;
  logic            last_in;

  assign idx_next = CmpW'(sample_idx_q) + CmpW'(1);
  assign last_in  = idx_next >= len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_idx_q <= '0;
      car_idx_q    <= '0;
    end else if (in_fire) begin
      if (last_in) begin
        sample_idx_q <= '0;
        car_idx_q    <= '0;
      end else begin
        sample_idx_q <= idx_next[IdxW-1:0];
        car_idx_q    <= (car_idx_q == CarW'(CarrierPeriod - 1)) ? '0 : car_idx_q + CarW'(1);
      end
    end
  end

  // Reference angle in 1/(8*period) turn units, wrapped once
  logic [SumW-1:0] ang_sum;
  logic [AngW-1:0] ang_idx;
  coef_t           coef;

  assign ang_sum = (SumW'(car_idx_q) << 3) + SumW'(phase_q) * SumW'(CarrierPeriod);
  assign ang_idx = (ang_sum >= SumW'(TabDepth)) ? AngW'(ang_sum - SumW'(TabDepth))
                                                 : AngW'(ang_sum);

  qpskcd_carrier_rom #(
    .CarrierPeriod(CarrierPeriod)
  ) u_carrier_rom (
    .angle_i(ang_idx),
    .coef_o (coef)
  );

  // Stage 1: sample and coefficients
  logic signed [SampleWidth-1:0] sample1_q;
  coef_t                         coef1_q;
  logic                          refm1_q, refl1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample1_q <= s_axis_tdata[SampleWidth-1:0];
      refm1_q   <= s_axis_tdata[SampleWidth];
      refl1_q   <= s_axis_tdata[SampleWidth+1];
      last1_q   <= last_in;
      coef1_q   <= coef;
    end
  end

  // Stage 2: products
  logic signed [ProdW-1:0] pc2_q, ps2_q;
  logic                    refm2_q, refl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (!v2_q || fire2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      pc2_q   <= sample1_q * coef1_q.cos_v;
      ps2_q   <= sample1_q * coef1_q.sin_v;
      refm2_q <= refm1_q;
      refl2_q <= refl1_q;
      last2_q <= last1_q;
    end
  end

  // Stage 3: accumulate, decide on the symbol's last sample
  logic signed [AccW-1:0] acc_cos_q, acc_sin_q;
  logic signed [AccW-1:0] sum_cos, sum_sin;
  logic                   dec_msb, dec_lsb, e_msb, e_lsb;
  logic [ErrTotalW-1:0]   err_cnt_q, err_next;
  logic [ErrSumW-1:0]     err_sum;
  logic                   bm_q, bl_q, em_q, el_q;

  assign sum_cos = acc_cos_q + AccW'(pc2_q);
  assign sum_sin = acc_sin_q + AccW'(ps2_q);
  assign dec_msb = !sum_cos[AccW-1] && (sum_cos != '0);
  assign dec_lsb = !sum_sin[AccW-1] && (sum_sin != '0);
  assign e_msb   = dec_msb ^ refm2_q;
  assign e_lsb   = dec_lsb ^ refl2_q;
  assign err_sum = ErrSumW'(err_cnt_q) + ErrSumW'(e_msb) + ErrSumW'(e_lsb);
  // saturate at all ones
  assign err_next = err_sum[ErrTotalW] ? '1 : err_sum[ErrTotalW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cos_q   <= '0;
      acc_sin_q   <= '0;
      err_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire2) begin
        if (last2_q) begin
          acc_cos_q <= '0;
          acc_sin_q <= '0;
          err_cnt_q <= err_next;
        end else begin
          acc_cos_q <= sum_cos;
          acc_sin_q <= sum_sin;
        end
      end
      if (fire2 && last2_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2 && last2_q) begin
      bm_q <= dec_msb;
      bl_q <= dec_lsb;
      em_q <= e_msb;
      el_q <= e_lsb;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({err_cnt_q, el_q, em_q, bl_q, bm_q});

endmodule

`default_nettype wire

/* rtl/core/qpskcd_carrier_rom.sv */
// Constant cosine/sine reference table over one carrier turn, built at
// elaboration from a truncated Taylor series. Uses qpskcd_pkg. Combinational read.
`default_nettype none

module qpskcd_carrier_rom import qpskcd_pkg::*; #(
  parameter int CarrierPeriod = CarrierPeriodDef
) (
  input  wire logic [$clog2(8*CarrierPeriod)-1:0] angle_i,
  output coef_t                                   coef_o
);

  localparam int TabDepth = 8 * CarrierPeriod;

  coef_t tab [TabDepth];

  // One entry per 1/(8*period) of a turn; quadrant symmetry folded in here
  for (genvar a = 0; a < TabDepth; a++) begin : g_tab
    localparam int     Quad = a / (2 * CarrierPeriod);
    localparam longint Rem  = a % (2 * CarrierPeriod);
    localparam longint XQ30 = (PiQ30 * Rem + 2 * CarrierPeriod) / (4 * CarrierPeriod);
    // Series terms in Q30, each truncated before the next one is built
    localparam longint T1  = (OneQ30 * XQ30) >>> 30;
    localparam longint T2  = ((T1 * XQ30) >>> 30) / 2;
    localparam longint T3  = ((T2 * XQ30) >>> 30) / 3;
    localparam longint T4  = ((T3 * XQ30) >>> 30) / 4;
    localparam longint T5  = ((T4 * XQ30) >>> 30) / 5;
    localparam longint T6  = ((T5 * XQ30) >>> 30) / 6;
    localparam longint T7  = ((T6 * XQ30) >>> 30) / 7;
    localparam longint T8  = ((T7 * XQ30) >>> 30) / 8;
    localparam longint T9  = ((T8 * XQ30) >>> 30) / 9;
    localparam longint T10 = ((T9 * XQ30) >>> 30) / 10;
    localparam longint T11 = ((T10 * XQ30) >>> 30) / 11;
    localparam longint T12 = ((T11 * XQ30) >>> 30) / 12;
    localparam longint T13 = ((T12 * XQ30) >>> 30) / 13;
    localparam longint T14 = ((T13 * XQ30) >>> 30) / 14;
    localparam longint T15 = ((T14 * XQ30) >>> 30) / 15;
    localparam longint CSum = OneQ30 - T2 + T4 - T6 + T8 - T10 + T12 - T14;
    localparam longint SSum = T1 - T3 + T5 - T7 + T9 - T11 + T13 - T15;
    localparam longint CPos = (CSum < 0) ? 64'sd0 : CSum;
    localparam longint SPos = (SSum < 0) ? 64'sd0 : SSum;
    localparam longint CosQ14 = (CPos + 64'sd32768) >>> 16;
    localparam longint SinQ14 = (SPos + 64'sd32768) >>> 16;
    localparam logic signed [CoefW-1:0] CosBase = CoefW'(CosQ14);
    localparam logic signed [CoefW-1:0] SinBase = CoefW'(SinQ14);
    localparam logic signed [CoefW-1:0] CosVal =
      (Quad == 0) ? CosBase :
      (Quad == 1) ? -SinBase :
      (Quad == 2) ? -CosBase : SinBase;
    localparam logic signed [CoefW-1:0] SinVal =
      (Quad == 0) ? SinBase :
      (Quad == 1) ? CosBase :
      (Quad == 2) ? -SinBase : -CosBase;
    assign tab[a] = '{cos_v: CosVal, sin_v: SinVal};
  end

  assign coef_o = tab[angle_i];

endmodule

`default_nettype wire

/* rtl/core/qpskcd_checker.sv */
// Port-level assertions for the QPSK correlation demodulator, bound to
// qpsk_correlation_demodulator_top. Uses qpskcd_pkg.
`default_nettype none

module qpskcd_checker import qpskcd_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic                 out_fire;
  logic [ErrTotalW-1:0] total, last_total_q, total_exp;
  logic [ErrTotalW:0]   total_sum;

  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign total     = m_axis_tdata[OutTotalLsb +: ErrTotalW];
  assign total_sum = (ErrTotalW+1)'(last_total_q)
                   + (ErrTotalW+1)'(m_axis_tdata[OutErrMsb])
                   + (ErrTotalW+1)'(m_axis_tdata[OutErrLsb]);
  assign total_exp = total_sum[ErrTotalW] ? '1 : total_sum[ErrTotalW-1:0];

  // track the error total of the previous delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_fire) begin
      last_total_q <= total;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> total == total_exp)
    else $error("error total does not follow the error flags");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind qpsk_correlation_demodulator_top qpskcd_checker u_qpskcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for qpsk_correlation_demodulator_top: streams sample beats in,
// predicts each symbol decision and checks every result beat. Uses qpskcd_pkg and the RTL.

module tb;
  import qpskcd_pkg::*;

  localparam int SmpW       = SampleWidthDef;
  localparam int InDataW    = ((SmpW + 2 + 7) / 8) * 8;
  localparam int Period     = CarrierPeriodDef;
  localparam int AngleSteps = 8 * Period;

  typedef struct {
    bit                 bit_msb;
    bit                 bit_lsb;
    bit                 err_msb;
    bit                 err_lsb;
    bit [ErrTotalW-1:0] total;
  } decision_t;

  class decision_scoreboard;
    longint          cos_tab[AngleSteps];
    longint          sin_tab[AngleSteps];
    bit [SpsW-1:0]   sym_len;
    bit [PhaseW-1:0] phase;
    int              taken;
    int              carrier_pos;
    longint          acc_cos;
    longint          acc_sin;
    int unsigned     err_count;
    decision_t       expected_decisions[$];
    int              fails;

    function new();
      longint x;
      longint term;
      longint c;
      longint s;
      for (int a = 0; a < AngleSteps; a++) begin
        x    = (PiQ30 * longint'(a % (2 * Period)) + 2 * Period) / (4 * Period);
        term = OneQ30;
        c    = OneQ30;
        s    = 0;
        // Taylor terms alternate between the sine and cosine sums
        for (int n = 1; n <= 15; n++) begin
          term = ((term * x) >>> 30) / n;
          case (n % 4)
            1: s = s + term;
            2: c = c - term;
            3: s = s - term;
            default: c = c + term;
          endcase
        end
        if (c < 0) c = 0;
        if (s < 0) s = 0;
        c = (c + 32768) >>> 16;
        s = (s + 32768) >>> 16;
        case (a / (2 * Period))
          0: begin cos_tab[a] = c;  sin_tab[a] = s;  end
          1: begin cos_tab[a] = -s; sin_tab[a] = c;  end
          2: begin cos_tab[a] = -c; sin_tab[a] = -s; end
          default: begin cos_tab[a] = s; sin_tab[a] = -c; end
        endcase
      end
      sym_len     = SpsResetVal;
      phase       = PhaseResetVal;
      taken       = 0;
      carrier_pos = 0;
      acc_cos     = 0;
      acc_sin     = 0;
      err_count   = 0;
      fails       = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CfgSps:   sym_len = v[SpsW-1:0];
        CfgPhase: phase   = v[PhaseW-1:0];
        default: ;
      endcase
    endfunction

    function int angle_now();
      return (8 * carrier_pos + Period * int'(phase)) % AngleSteps;
    endfunction

    function longint cos_now();
      return cos_tab[angle_now()];
    endfunction

    function longint sin_now();
      return sin_tab[angle_now()];
    endfunction

    function int sym_pos();
      return taken;
    endfunction

    function int pending();
      return expected_decisions.size();
    endfunction

    function void note_sample(logic signed [SmpW-1:0] smp, bit rm, bit rl);
      int        len;
      int        ang;
      decision_t d;
      len = (sym_len == 0) ? 1 : int'(sym_len);
      if (len > MaxSamplesDef) len = MaxSamplesDef;
      ang = angle_now();
      acc_cos = acc_cos + longint'(smp) * cos_tab[ang];
      acc_sin = acc_sin + longint'(smp) * sin_tab[ang];
      taken++;
      carrier_pos = (carrier_pos + 1) % Period;
      if (taken < len) return;
      d.bit_msb = acc_cos > 0;
      d.bit_lsb = acc_sin > 0;
      d.err_msb = d.bit_msb ^ rm;
      d.err_lsb = d.bit_lsb ^ rl;
      err_count = err_count + int'(d.err_msb) + int'(d.err_lsb);
      if (err_count > 65535) err_count = 65535;
      d.total = err_count[ErrTotalW-1:0];
      expected_decisions.push_back(d);
      taken       = 0;
      carrier_pos = 0;
      acc_cos     = 0;
      acc_sin     = 0;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] beat);
      decision_t want;
      if (expected_decisions.size() == 0) begin
        $display("%0t: result beat %h expected none actual one", $time, beat);
        fails++;
        return;
      end
      want = expected_decisions.pop_front();
      compare_field("bit_msb", 16'(want.bit_msb), 16'(beat[OutBitMsb]));
      compare_field("bit_lsb", 16'(want.bit_lsb), 16'(beat[OutBitLsb]));
      compare_field("err_msb", 16'(want.err_msb), 16'(beat[OutErrMsb]));
      compare_field("err_lsb", 16'(want.err_lsb), 16'(beat[OutErrLsb]));
      compare_field("error_total", want.total, beat[OutTotalLsb +: ErrTotalW]);
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  bit hold_req  = 1'b0;
  bit sink_fast = 1'b0;

  decision_scoreboard sb = new();

  qpsk_correlation_demodulator_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic int pick_gap(bit fast);
    int roll;
    roll = $urandom_range(0, 99);
    if (fast) return (roll < 97) ? 0 : $urandom_range(1, 3);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SpsW-1:0] pick_len();
    int len;
    case ($urandom_range(0, 19))
      0: len = 0;
      1: len = 1;
      2: len = 2;
      3: len = 3;
      4: len = 4;
      5: len = 5;
      6: len = 6;
      7: len = 7;
      8: len = 8;
      9: len = 10;
      10: len = 12;
      11: len = 16;
      12: len = 20;
      13: len = 33;
      14: len = 40;
      15: len = 63;
      16: len = 64;
      17: len = 65;
      18: len = 100;
      default: len = 127;
    endcase
    return SpsW'(len);
  endfunction

  // Mostly a clean carrier for the intended bits plus noise; some raw and extreme values.
  function automatic logic signed [SmpW-1:0] shaped_sample(bit bm, bit bl);
    int     roll;
    int     noise;
    longint amp;
    longint v;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      v = longint'($urandom_range(0, 65535)) - 32768;
    end else if (roll < 20) begin
      case ($urandom_range(0, 4))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else begin
      amp   = $urandom_range(500, 16000);
      noise = $urandom_range(0, 3000);
      v = ((bm ? amp : -amp) * sb.cos_now() + (bl ? amp : -amp) * sb.sin_now()) >>> 14;
      v = v + longint'($urandom_range(0, 2 * noise)) - noise;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    return v[SmpW-1:0];
  endfunction

  task automatic push_beat(logic signed [SmpW-1:0] smp, bit rm, bit rl, bit fast);
    int gap;
    gap = pick_gap(fast);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - SmpW - 2){1'b0}}, rl, rm, smp};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(smp, rm, rl);
    @(negedge clk);
  endtask

  task automatic run_random(int n, bit fast);
    bit tx_m;
    bit tx_l;
    bit rm;
    bit rl;
    for (int i = 0; i < n; i++) begin
      if (sb.sym_pos() == 0) begin
        tx_m = 1'($urandom_range(0, 1));
        tx_l = 1'($urandom_range(0, 1));
      end
      rm = tx_m ^ ($urandom_range(0, 9) == 0);
      rl = tx_l ^ ($urandom_range(0, 9) == 0);
      push_beat(shaped_sample(tx_m, tx_l), rm, rl, fast);
    end
  endtask

  // Drop valid, wait for every decision, then let the pipeline drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap(sink_fast);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] v;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one symbol at the reset settings
    run_random(40, 1'b0);
    settle();

    // zero length acts as one; full-scale samples and a zero sum
    cfg_write(CfgSps, CfgDataW'(0));
    cfg_write(CfgPhase, CfgDataW'(0));
    push_beat(16'sh7FFF, 1'b1, 1'b0, 1'b0);
    push_beat(16'sh8000, 1'b1, 1'b1, 1'b0);
    push_beat(16'sh0000, 1'b0, 1'b1, 1'b0);
    settle();

    // every carrier phase, one sample per symbol
    cfg_write(CfgSps, CfgDataW'(1));
    for (int p = 0; p < 8; p++) begin
      v = CfgDataW'($urandom_range(0, 127));
      v[PhaseW-1:0] = PhaseW'(p);
      cfg_write(CfgPhase, v);
      push_beat(16'sd20000, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
      settle();
    end

    // shorten the symbol after three of four samples are in
    cfg_write(CfgSps, CfgDataW'(4));
    cfg_write(CfgPhase, CfgDataW'(2));
    run_random(3, 1'b0);
    settle();
    cfg_write(CfgSps, CfgDataW'(2));
    run_random(1, 1'b0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0 || $urandom_range(0, 3) != 0) cfg_write(CfgSps, pick_len());
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        cfg_write(CfgPhase, CfgDataW'($urandom_range(0, 127)));
      end
      if (ph == 4) begin
        cfg_write(CfgSps, CfgDataW'(1));
        hold_req = 1'b1;
      end
      run_random($urandom_range(70, 100), 1'b0);
      settle();
    end

    // two errors per symbol with a fast sink
    cfg_write(CfgSps, CfgDataW'(1));
    cfg_write(CfgPhase, CfgDataW'(0));
    sink_fast = 1'b1;
    for (int i = 0; i < 100; i++) begin
      push_beat(SmpW'($urandom_range(1, 32767)), 1'b0, 1'b1, 1'b1);
    end
    settle();
    sink_fast = 1'b0;
    cfg_write(CfgSps, CfgDataW'(3));
    run_random(30, 1'b0);

    s_tvalid <= 1'b0;
    for (int w = 0; w < 100000 && sb.pending() != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d decisions expected but never seen", $time, sb.pending());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/core/qpskcd_pkg.sv
rtl/core/qpskcd_carrier_rom.sv
rtl/core/qpsk_correlation_demodulator_top.sv
rtl/core/qpskcd_checker.sv
tb/tb.sv
